>>> rtl/hhp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hhp_pkg: shared types and constants of the hex hash list parser
// Item and result payloads, result kinds, parser phases and the command
// flags that travel from the front end to the back end.
// ---------------------------------------------------------------------------
package hhp_pkg;

  localparam int unsigned HashBytesW = 6;
  localparam logic [HashBytesW-1:0] HashBytesReset = 6'd20;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  typedef enum logic [2:0] {
    KIND_NODE    = 3'd0,
    KIND_TGT     = 3'd1,
    KIND_END_TGT = 3'd2,
    KIND_END_SEQ = 3'd3,
    KIND_BAD     = 3'd4,
    KIND_READ    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_NODE = 2'd0,
    PH_TGT  = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
    logic       read_fault;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
    logic       last;
  } result_t;

  // One command per input item that yields results.
  typedef struct packed {
    kind_e hash_kind;
    logic  has_hash;
    logic  bank;
    logic  end_tgt;
    logic  end_seq;
    logic  err;
    kind_e err_kind;
  } cmd_flags_t;

endpackage

`default_nettype wire

>>> rtl/hex_hash_list_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hex_hash_list_parser: hex hash adjacency list parser
// Parses node and target hashes from a character stream into hash bytes.
// ---------------------------------------------------------------------------
// One character request is taken per cycle while full is low. Every item,
// digits and blanks included, waits while full is high. Each item that yields
// results becomes a command in a two-entry queue; the back end loads it,
// then expands it at one result per cycle while the result queue has room.
// The hash store has two banks: full rises while both banks hold hashes
// that still await emission, or the command queue is full. There is no
// clearing pass after reset.
module hex_hash_list_parser
  import hhp_pkg::*;
#(
  parameter int unsigned MaxHashBytes = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire item_t                 item_i,
  output logic                       empty,
  input  wire logic                  pop,
  output result_t                    result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [HashBytesW-1:0] cfg_wdata_i
);

  localparam int unsigned LenW  = $clog2(MaxHashBytes + 1);
  localparam int unsigned AddrW = (MaxHashBytes > 1) ? $clog2(MaxHashBytes) : 1;
  localparam int unsigned CmdW  = $bits(cmd_flags_t) + 2 * LenW;

  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_flags_t      wr_flags, rd_flags;
  logic [LenW-1:0] wr_zeros, wr_nbytes, rd_zeros, rd_nbytes;
  logic [CmdW-1:0] cmd_wdata, cmd_rdata;
  logic [$clog2(2+1)-1:0] cmd_count;
  logic            hash_done, mem_we;
  logic [AddrW:0]  mem_waddr;
  logic [7:0]      mem_wdata;

  hhp_front #(
    .MaxHashBytes(MaxHashBytes),
    .LenW        (LenW),
    .AddrW       (AddrW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_flags_o (wr_flags),
    .cmd_zeros_o (wr_zeros),
    .cmd_nbytes_o(wr_nbytes),
    .hash_done_i (hash_done),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  assign cmd_wdata = {wr_flags, wr_zeros, wr_nbytes};

  hhp_fifo #(
    .Width(CmdW),
    .Depth(2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wdata),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rdata),
    .empty_o(cmd_empty),
    .count_o(cmd_count)
  );

  assign {rd_flags, rd_zeros, rd_nbytes} = cmd_rdata;

  hhp_back #(
    .LenW (LenW),
    .AddrW(AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .cmd_flags_i (rd_flags),
    .cmd_zeros_i (rd_zeros),
    .cmd_nbytes_i(rd_nbytes),
    .hash_done_o (hash_done),
    .mem_we_i    (mem_we),
    .mem_waddr_i (mem_waddr),
    .mem_wdata_i (mem_wdata),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

  // Occupancy is tracked by the full and empty flags alone.
  logic unused_count;
  assign unused_count = ^cmd_count;

endmodule

`default_nettype wire

>>> rtl/hhp_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hhp_fifo: small flop based queue
// Push and pop in the same cycle; head entry is shown while not empty.
// ---------------------------------------------------------------------------
module hhp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic [Width-1:0]               wdata_i,
  output logic                                full_o,
  input  wire logic                           pop_i,
  output logic [Width-1:0]                    rdata_o,
  output logic                                empty_o,
  output logic [$clog2(Depth+1)-1:0]          count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hhp_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hhp_front: character classifier and parser state
// Takes one request per cycle while not full, tracks node/target phase,
// packs hex digits into hash store bytes, issues one command per result group.
// ---------------------------------------------------------------------------
module hhp_front
  import hhp_pkg::*;
#(
  parameter int unsigned MaxHashBytes = 32,
  parameter int unsigned LenW         = 6,
  parameter int unsigned AddrW        = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire item_t                 item_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [HashBytesW-1:0] cfg_wdata_i,
  input  wire logic                  cmd_full_i,
  output logic                       cmd_push_o,
  output cmd_flags_t                 cmd_flags_o,
  output logic [LenW-1:0]            cmd_zeros_o,
  output logic [LenW-1:0]            cmd_nbytes_o,
  input  wire logic                  hash_done_i,
  output logic                       mem_we_o,
  output logic [AddrW:0]             mem_waddr_o,
  output logic [7:0]                 mem_wdata_o
);

  phase_e                phase_q, phase_d;
  logic                  in_digits_q, in_digits_d;
  logic                  expect_high_q, expect_high_d;
  logic [LenW-1:0]       filled_q, filled_d;
  logic [3:0]            nib_q, nib_d;
  kind_e                 err_q, err_d;
  logic                  bank_q, bank_d;
  logic [1:0]            hcount_q, hcount_d;
  logic [HashBytesW-1:0] hash_bytes_q;

  logic       accept;
  logic [LenW-1:0] len;
  logic       is_ws, is_eol, nib_ok, digit, do_fail;
  logic [3:0] nib;
  kind_e      fail_kind;
  cmd_flags_t fl;

  always_comb begin
    if (hash_bytes_q == '0) begin
      len = LenW'(1);
    end else if (32'(hash_bytes_q) > MaxHashBytes) begin
      len = LenW'(MaxHashBytes);
    end else begin
      len = LenW'(hash_bytes_q);
    end
  end

  assign is_ws  = (item_i.ch == ChSpace) || (item_i.ch >= ChTab && item_i.ch <= ChCr);
  assign is_eol = (item_i.ch == ChCr) || (item_i.ch == ChLf);

  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'h0;
    if (item_i.ch >= "0" && item_i.ch <= "9") begin
      nib = 4'(item_i.ch - "0");
    end else if (item_i.ch >= "A" && item_i.ch <= "F") begin
      nib = 4'(item_i.ch - "A" + 8'd10);
    end else if (item_i.ch >= "a" && item_i.ch <= "f") begin
      nib = 4'(item_i.ch - "a" + 8'd10);
    end else begin
      nib_ok = 1'b0;
    end
  end

  // Hold input while both store banks await emission or the command queue is full.
  assign full_o = cmd_full_i || (hcount_q == 2'd2);
  assign accept = push_i && !full_o;

  always_comb begin
    phase_d       = phase_q;
    in_digits_d   = in_digits_q;
    expect_high_d = expect_high_q;
    filled_d      = filled_q;
    nib_d         = nib_q;
    err_d         = err_q;
    bank_d        = bank_q;
    fl            = '0;
    fl.hash_kind  = (phase_q == PH_NODE) ? KIND_NODE : KIND_TGT;
    fl.err_kind   = KIND_BAD;
    fl.bank       = bank_q;
    cmd_push_o    = 1'b0;
    cmd_zeros_o   = '0;
    cmd_nbytes_o  = '0;
    mem_we_o      = 1'b0;
    digit         = 1'b0;
    do_fail       = 1'b0;
    fail_kind     = KIND_BAD;

    if (accept) begin
      if (phase_q == PH_DONE) begin
        fl.end_seq = 1'b1;
        cmd_push_o = 1'b1;
      end else if (phase_q == PH_ERR) begin
        fl.err      = 1'b1;
        fl.err_kind = err_q;
        cmd_push_o  = 1'b1;
      end else if (item_i.read_fault) begin
        do_fail   = 1'b1;
        fail_kind = KIND_READ;
      end else if (in_digits_q) begin
        if (!item_i.at_end && !is_ws) begin
          digit = 1'b1;
        end else if (!expect_high_q || filled_q > len) begin
          do_fail = 1'b1;
        end else begin
          // Close the hash: leading zeros, then the stored bytes.
          fl.has_hash   = 1'b1;
          cmd_zeros_o   = len - filled_q;
          cmd_nbytes_o  = filled_q;
          cmd_push_o    = 1'b1;
          bank_d        = ~bank_q;
          in_digits_d   = 1'b0;
          expect_high_d = 1'b1;
          filled_d      = '0;
          phase_d       = PH_TGT;
          if (item_i.at_end) begin
            fl.end_tgt = 1'b1;
            fl.end_seq = 1'b1;
            phase_d    = PH_DONE;
          end else if (is_eol) begin
            fl.end_tgt = 1'b1;
            phase_d    = PH_NODE;
          end
        end
      end else begin
        if (item_i.at_end) begin
          fl.end_tgt = (phase_q == PH_TGT);
          fl.end_seq = 1'b1;
          cmd_push_o = 1'b1;
          phase_d    = PH_DONE;
        end else if (phase_q == PH_TGT && is_eol) begin
          fl.end_tgt = 1'b1;
          cmd_push_o = 1'b1;
          phase_d    = PH_NODE;
        end else if (!is_ws) begin
          in_digits_d = 1'b1;
          digit       = 1'b1;
        end
      end

      // Outside a hash filled is zero and a high nibble is due.
      if (digit) begin
        if (!nib_ok || filled_q >= len) begin
          do_fail = 1'b1;
        end else if (expect_high_q) begin
          nib_d         = nib;
          expect_high_d = 1'b0;
        end else begin
          mem_we_o      = 1'b1;
          expect_high_d = 1'b1;
          filled_d      = filled_q + 1'b1;
        end
      end

      if (do_fail) begin
        fl             = '0;
        fl.hash_kind   = KIND_NODE;
        fl.bank        = bank_q;
        fl.err         = 1'b1;
        fl.err_kind    = fail_kind;
        cmd_zeros_o    = '0;
        cmd_nbytes_o   = '0;
        cmd_push_o     = 1'b1;
        mem_we_o       = 1'b0;
        bank_d         = bank_q;
        phase_d        = PH_ERR;
        err_d          = fail_kind;
        in_digits_d    = 1'b0;
        expect_high_d  = 1'b1;
        filled_d       = '0;
      end
    end
  end

  assign cmd_flags_o = fl;
  assign mem_waddr_o = {bank_q, filled_q[AddrW-1:0]};
  assign mem_wdata_o = {nib_q, nib};

  always_comb begin
    hcount_d = hcount_q;
    if ((cmd_push_o && fl.has_hash) && !hash_done_i) begin
      hcount_d = hcount_q + 1'b1;
    end else if (!(cmd_push_o && fl.has_hash) && hash_done_i) begin
      hcount_d = hcount_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_NODE;
      in_digits_q   <= 1'b0;
      expect_high_q <= 1'b1;
      filled_q      <= '0;
      err_q         <= KIND_BAD;
      bank_q        <= 1'b0;
      hcount_q      <= '0;
      hash_bytes_q  <= HashBytesReset;
    end else begin
      phase_q       <= phase_d;
      in_digits_q   <= in_digits_d;
      expect_high_q <= expect_high_d;
      filled_q      <= filled_d;
      err_q         <= err_d;
      bank_q        <= bank_d;
      hcount_q      <= hcount_d;
      if (cfg_we_i) begin
        hash_bytes_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nib_q <= nib_d;
  end

endmodule

`default_nettype wire

>>> rtl/hhp_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hhp_back: result sequencer
// Holds the two-bank hash store, expands each command into result items
// one per cycle while the result queue has room, and buffers them in it.
// ---------------------------------------------------------------------------
module hhp_back
  import hhp_pkg::*;
#(
  parameter int unsigned LenW  = 6,
  parameter int unsigned AddrW = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_empty_i,
  output logic                 cmd_pop_o,
  input  wire cmd_flags_t      cmd_flags_i,
  input  wire logic [LenW-1:0] cmd_zeros_i,
  input  wire logic [LenW-1:0] cmd_nbytes_i,
  output logic                 hash_done_o,
  input  wire logic            mem_we_i,
  input  wire logic [AddrW:0]  mem_waddr_i,
  input  wire logic [7:0]      mem_wdata_i,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output result_t              result_o
);

  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  logic [7:0] mem_q [2**(AddrW+1)];
  logic [7:0] rd_data_q;

  logic            cur_v_q, cur_v_d;
  cmd_flags_t      cur_q, cur_d;
  logic [LenW-1:0] zl_q, zl_d, bl_q, bl_d;
  logic [AddrW-1:0] idx_q, idx_d;

  logic  infl_v_q, infl_mem_q, infl_last_q;
  kind_e infl_kind_q;

  logic               rd_en, issue, room, emit_mem, emit_last;
  kind_e              emit_kind;
  logic [OutCntW-1:0] res_count;
  logic               res_full;
  result_t            res_w;
  logic [$bits(result_t)-1:0] res_rdata;

  // Count the item in flight so the queue never overflows.
  assign room  = ({1'b0, res_count} + (OutCntW + 1)'(infl_v_q)) < (OutCntW + 1)'(OutDepth);
  assign issue = cur_v_q && room;
  assign cmd_pop_o = !cur_v_q && !cmd_empty_i;

  always_comb begin
    cur_v_d     = cur_v_q;
    cur_d       = cur_q;
    zl_d        = zl_q;
    bl_d        = bl_q;
    idx_d       = idx_q;
    rd_en       = 1'b0;
    emit_kind   = cur_q.hash_kind;
    emit_mem    = 1'b0;
    emit_last   = 1'b0;
    hash_done_o = 1'b0;
    if (cmd_pop_o) begin
      cur_v_d = 1'b1;
      cur_d   = cmd_flags_i;
      zl_d    = cmd_zeros_i;
      bl_d    = cmd_nbytes_i;
      idx_d   = '0;
    end else if (issue) begin
      if (zl_q != '0) begin
        zl_d = zl_q - 1'b1;
      end else if (bl_q != '0) begin
        bl_d     = bl_q - 1'b1;
        idx_d    = idx_q + 1'b1;
        rd_en    = 1'b1;
        emit_mem = 1'b1;
      end else if (cur_q.end_tgt) begin
        cur_d.end_tgt = 1'b0;
        emit_kind     = KIND_END_TGT;
      end else if (cur_q.end_seq) begin
        cur_d.end_seq = 1'b0;
        emit_kind     = KIND_END_SEQ;
      end else begin
        cur_d.err = 1'b0;
        emit_kind = cur_q.err_kind;
      end
      emit_last = (zl_d == '0) && (bl_d == '0) && !cur_d.end_tgt && !cur_d.end_seq
                  && !cur_d.err;
      if (emit_last) begin
        cur_v_d     = 1'b0;
        hash_done_o = cur_q.has_hash;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q  <= 1'b0;
      infl_v_q <= 1'b0;
    end else begin
      cur_v_q  <= cur_v_d;
      infl_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    zl_q        <= zl_d;
    bl_q        <= bl_d;
    idx_q       <= idx_d;
    infl_kind_q <= emit_kind;
    infl_mem_q  <= emit_mem;
    infl_last_q <= emit_last;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[mem_waddr_i] <= mem_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[{cur_q.bank, idx_q}];
    end
  end

  always_comb begin
    res_w.kind       = infl_kind_q;
    res_w.byte_value = infl_mem_q ? rd_data_q : 8'h00;
    res_w.last       = infl_last_q;
  end

  hhp_fifo #(
    .Width($bits(result_t)),
    .Depth(OutDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (infl_v_q),
    .wdata_i(res_w),
    .full_o (res_full),
    .pop_i  (pop_i),
    .rdata_o(res_rdata),
    .empty_o(empty_o),
    .count_o(res_count)
  );

  assign result_o = result_t'(res_rdata);

  // The room check keeps pushes off a full queue.
  logic unused_full;
  assign unused_full = res_full;

endmodule

`default_nettype wire

>>> rtl/hhp_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hhp_checker: port level checks of the hex hash list parser
// Watches the result side of the top level over time.
// ---------------------------------------------------------------------------
module hhp_checker
  import hhp_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    empty,
  input wire logic    pop,
  input wire result_t result_o
);

  // Nothing is waiting right after reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result queue not empty after reset");

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("stalled result changed");

  // Only hash bytes carry a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.kind != KIND_NODE && result_o.kind != KIND_TGT)
      |-> (result_o.byte_value == 8'h00))
    else $error("non-hash result carries a byte value");

  // End of sequence and errors always close the request's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.kind == KIND_END_SEQ || result_o.kind == KIND_BAD
                || result_o.kind == KIND_READ)) |-> result_o.last)
    else $error("terminal result not marked last");

endmodule

bind hex_hash_list_parser hhp_checker u_hhp_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .empty   (empty),
  .pop     (pop),
  .result_o(result_o)
);

`default_nettype wire

>>> bench/hex_hash_list_parser_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hex_hash_list_parser_tb: self-checking bench of the hex hash list parser
// Streams adjacency-list text in phases of different hash lengths. A
// scoreboard predicts every hash byte and end marker and checks each popped
// result against it. Each run closes the stream with one end or error case
// and then probes the sticky state with random items.
// ---------------------------------------------------------------------------
module hex_hash_list_parser_tb;
  import hhp_pkg::*;

  localparam int unsigned MaxStore   = 32;
  localparam int unsigned Settle     = 2 * MaxStore + 16;
  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned PhaseItems = 25;
  localparam int unsigned TailItems  = 20;
  localparam int unsigned ReportMax  = 10;

  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerA = 8'h61;

  typedef enum int {
    CLOSE_END_IN_HASH,
    CLOSE_END_TARGETS,
    CLOSE_END_NODES,
    CLOSE_BAD_CHAR,
    CLOSE_TOO_LONG,
    CLOSE_ODD_DIGITS,
    CLOSE_SHRUNK,
    CLOSE_READ_FAULT
  } close_e;

  class hash_scoreboard;
    phase_e                ph = PH_NODE;
    bit                    in_digits = 1'b0;
    bit                    expect_high = 1'b1;
    logic [7:0]            store [MaxStore];
    int unsigned           bytes_filled = 0;
    logic [HashBytesW-1:0] len_cfg = HashBytesReset;
    kind_e                 err_kind = KIND_BAD;
    result_t               expected [$];
    result_t               batch [$];
    int unsigned           mismatches = 0;
    int unsigned           checked = 0;

    static function bit is_space(input logic [7:0] c);
      return c == ChSpace || (c >= ChTab && c <= ChCr);
    endfunction

    static function bit hex_nibble(input logic [7:0] c, output logic [3:0] nib);
      nib = 4'h0;
      if (c >= ChZero && c <= ChZero + 8'd9) nib = 4'(c - ChZero);
      else if (c >= ChUpperA && c <= ChUpperA + 8'd5) nib = 4'(c - ChUpperA + 8'd10);
      else if (c >= ChLowerA && c <= ChLowerA + 8'd5) nib = 4'(c - ChLowerA + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function int unsigned eff_bytes();
      if (len_cfg == 0) return 1;
      if (len_cfg > MaxStore) return MaxStore;
      return len_cfg;
    endfunction

    function void emit(kind_e k, logic [7:0] v);
      result_t r;
      r.kind = k;
      r.byte_value = v;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void enter_error(kind_e k);
      emit(k, 8'h00);
      ph = PH_ERR;
      err_kind = k;
      in_digits = 1'b0;
      expect_high = 1'b1;
      bytes_filled = 0;
    endfunction

    function void take_digit(logic [7:0] c);
      logic [3:0] nib;
      if (!hex_nibble(c, nib) || bytes_filled >= eff_bytes()) begin
        enter_error(KIND_BAD);
        return;
      end
      if (expect_high) begin
        store[bytes_filled] = {nib, 4'h0};
        expect_high = 1'b0;
      end else begin
        store[bytes_filled][3:0] = nib;
        expect_high = 1'b1;
        bytes_filled++;
      end
    endfunction

    // Predict the results of one accepted character request.
    function void note_item(item_t it);
      int unsigned len;
      int unsigned i;
      kind_e       hk;
      result_t     r;
      batch.delete();
      if (ph == PH_DONE) begin
        emit(KIND_END_SEQ, 8'h00);
      end else if (ph == PH_ERR) begin
        emit(err_kind, 8'h00);
      end else if (it.read_fault) begin
        enter_error(KIND_READ);
      end else if (in_digits) begin
        if (!it.at_end && !is_space(it.ch)) begin
          take_digit(it.ch);
        end else begin
          len = eff_bytes();
          if (!expect_high || bytes_filled > len) begin
            enter_error(KIND_BAD);
          end else begin
            hk = (ph == PH_NODE) ? KIND_NODE : KIND_TGT;
            repeat (len - bytes_filled) emit(hk, 8'h00);
            for (i = 0; i < bytes_filled; i++) emit(hk, store[i]);
            in_digits = 1'b0;
            expect_high = 1'b1;
            bytes_filled = 0;
            ph = PH_TGT;
            if (it.at_end) begin
              emit(KIND_END_TGT, 8'h00);
              emit(KIND_END_SEQ, 8'h00);
              ph = PH_DONE;
            end else if (it.ch == ChCr || it.ch == ChLf) begin
              emit(KIND_END_TGT, 8'h00);
              ph = PH_NODE;
            end
          end
        end
      end else if (it.at_end) begin
        if (ph == PH_TGT) emit(KIND_END_TGT, 8'h00);
        emit(KIND_END_SEQ, 8'h00);
        ph = PH_DONE;
      end else if (ph == PH_TGT && (it.ch == ChCr || it.ch == ChLf)) begin
        emit(KIND_END_TGT, 8'h00);
        ph = PH_NODE;
      end else if (!is_space(it.ch)) begin
        in_digits = 1'b1;
        expect_high = 1'b1;
        bytes_filled = 0;
        take_digit(it.ch);
      end
      if (batch.size() > 0) begin
        r = batch[batch.size() - 1];
        r.last = 1'b1;
        batch[batch.size() - 1] = r;
      end
      foreach (batch[j]) expected.push_back(batch[j]);
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("result %0d unexpected: kind %0d byte %02h last %0b",
                   checked, got.kind, got.byte_value, got.last);
        return;
      end
      want = expected.pop_front();
      if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("result %0d: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                   checked, want.kind, want.byte_value, want.last,
                   got.kind, got.byte_value, got.last);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  item_t                 item_d = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  result_t               parsed;
  logic                  cfg_we = 1'b0;
  logic [HashBytesW-1:0] cfg_wdata = HashBytesReset;

  bit             gap_on = 1'b1;
  bit             stall_on = 1'b1;
  int unsigned    sent_items = 0;
  int unsigned    taken_items = 0;
  int unsigned    len_writes = 0;
  int unsigned    quiet_cycles = 0;
  hash_scoreboard sb;

  hex_hash_list_parser #(
    .MaxHashBytes(MaxStore)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .item_i     (item_d),
    .empty,
    .pop,
    .result_o   (parsed),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Monitor both queues, drive pop and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) sb.len_cfg = cfg_wdata;
      if (push && !full) begin
        sb.note_item(item_d);
        taken_items++;
      end
      if (pop && !empty) sb.check_result(parsed);
    end
    pop <= !stall_on || ($urandom_range(99) >= 22);
    if (rst_ni && ((push && !full) || (pop && !empty))) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog: no request moved for %0d cycles", WatchLimit);
      $display("hex_hash_list_parser_tb: done, errors");
      $finish;
    end
  end

  function automatic item_t make_item(logic [7:0] c, logic fin, logic fault);
    item_t it;
    it.ch = c;
    it.at_end = fin;
    it.read_fault = fault;
    return it;
  endfunction

  function automatic logic [7:0] rand_hex();
    logic [3:0] nib;
    nib = 4'($urandom_range(15));
    if (nib < 10) return ChZero + 8'(nib);
    return ($urandom_range(1) ? ChUpperA : ChLowerA) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChVt;
      default: return ChFf;
    endcase
  endfunction

  // Any whitespace, line ends included.
  function automatic logic [7:0] rand_space();
    case ($urandom_range(2))
      0: return ChCr;
      1: return ChLf;
      default: return rand_blank();
    endcase
  endfunction

  // Even digit count that fits the current hash length, often the full one.
  function automatic int unsigned rand_digits();
    if ($urandom_range(1)) return 2 * sb.eff_bytes();
    return 2 * $urandom_range(sb.eff_bytes(), 1);
  endfunction

  task automatic send_item(input item_t it);
    while (gap_on && $urandom_range(99) < 22) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item_d <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic send_ch(input logic [7:0] c);
    send_item(make_item(c, 1'b0, 1'b0));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_ch(s[i]);
  endtask

  task automatic send_hash(input int unsigned digits);
    repeat (digits) send_ch(rand_hex());
  endtask

  task automatic send_line();
    int unsigned targets;
    // Keep lines of long hashes short.
    targets = (sb.eff_bytes() > 8) ? $urandom_range(1) : $urandom_range(4);
    if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) send_ch(rand_space());
    send_hash(rand_digits());
    repeat (targets) begin
      repeat ($urandom_range(2, 1)) send_ch(rand_blank());
      send_hash(rand_digits());
    end
    if ($urandom_range(3) == 0) send_ch(rand_blank());
    case ($urandom_range(2))
      0: send_ch(ChLf);
      1: send_ch(ChCr);
      default: begin
        send_ch(ChCr);
        send_ch(ChLf);
      end
    endcase
  endtask

  // Hold the sender until every predicted result is back, then let the
  // back end settle.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.expected.size() != 0);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_len(input int unsigned v);
    cfg_we <= 1'b1;
    cfg_wdata <= HashBytesW'(v);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    len_writes++;
  endtask

  initial begin
    close_e      closing;
    int unsigned lens [8];
    int unsigned k;
    int unsigned start;
    logic [7:0]  c;
    logic [3:0]  nib;
    sb = new;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length: min and max bytes, both letter cases, LF, CRLF,
    // a node without targets.
    send_text("\n FF\t00 aB\r\n9f 12\ne3\n");

    lens = '{0, 32, 3, 63, 1, 6, 33, 2};
    lens[7] = $urandom_range(12, 2);
    for (int p = 0; p < 8; p++) begin
      drain_results();
      write_len(lens[p]);
      gap_on = (p != 3);
      stall_on = (p != 3);
      start = sent_items;
      while (sent_items - start < PhaseItems) begin
        send_line();
        if ($urandom_range(19) == 0) drain_results();
      end
    end
    gap_on = 1'b1;
    stall_on = 1'b1;

    // Close the stream with one end or error case.
    drain_results();
    closing = close_e'($urandom_range(CLOSE_READ_FAULT));
    case (closing)
      CLOSE_END_IN_HASH: begin
        if ($urandom_range(1)) begin
          send_hash(rand_digits());
          send_ch(rand_blank());
        end
        send_hash(rand_digits());
        send_item(make_item(8'($urandom_range(255)), 1'b1, 1'b0));
      end
      CLOSE_END_TARGETS: begin
        send_hash(rand_digits());
        send_ch(rand_blank());
        send_item(make_item(8'($urandom_range(255)), 1'b1, 1'b0));
      end
      CLOSE_END_NODES: send_item(make_item(8'($urandom_range(255)), 1'b1, 1'b0));
      CLOSE_BAD_CHAR: begin
        repeat ($urandom_range(3)) send_ch(rand_hex());
        do c = 8'($urandom_range(255));
        while (hash_scoreboard::is_space(c) || hash_scoreboard::hex_nibble(c, nib));
        send_ch(c);
      end
      CLOSE_TOO_LONG: send_hash(2 * sb.eff_bytes() + 1);
      CLOSE_ODD_DIGITS: begin
        send_hash(2 * $urandom_range(sb.eff_bytes() - 1, 0) + 1);
        send_ch(rand_space());
      end
      CLOSE_SHRUNK: begin
        // Shrink the length below the bytes already read, then close.
        k = $urandom_range(sb.eff_bytes(), 2);
        send_hash(2 * k);
        drain_results();
        write_len(k - 1);
        send_ch(rand_blank());
      end
      default: begin
        repeat ($urandom_range(3)) send_ch(rand_hex());
        send_item(make_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1));
      end
    endcase
    repeat (TailItems)
      send_item(make_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1))));
    drain_results();

    $display("covered %0d characters under %0d length settings, %0d results checked",
             taken_items, len_writes, sb.checked);
    $display("stream closed by %s, then %0d random items against the final state",
             closing.name(), TailItems);
    if (sb.mismatches == 0 && sb.expected.size() == 0) begin
      $display("hex_hash_list_parser_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches,
               sb.expected.size());
      $display("hex_hash_list_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
